[rtl/core/bdu_pkg.sv]
`timescale 1ns / 1ps

package bdu_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int SAMPLE_MAX = 1023;
   localparam int OUT_SUM_W  = 13;
   localparam int CSR_IDX_W  = 4;

   localparam int DETECT_RESET = 10;
   localparam int ARRIVE_RESET = 500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DETECT_THRESHOLD = 4'd0,
      CSR_ARRIVE_THRESHOLD = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_FRONT = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_RIGHT = 2'd2
   } dir_type;

endpackage

[rtl/core/bdu_if.sv]
`timescale 1ns / 1ps

interface bdu_req_if;
   import bdu_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] left_sample;
   logic [SAMPLE_W-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface bdu_rsp_if;
   import bdu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           direction;
   logic                 arrived;
   logic [OUT_SUM_W-1:0] left_window_sum;
   logic [OUT_SUM_W-1:0] right_window_sum;

   modport source (output valid, output direction, output arrived,
                   output left_window_sum, output right_window_sum, input ready);
   modport sink   (input valid, input direction, input arrived,
                   input left_window_sum, input right_window_sum, output ready);
endinterface

interface bdu_csr_if;
   import bdu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SAMPLE_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/bdu_window.sv]
`timescale 1ns / 1ps

module bdu_window
   import bdu_pkg::*;
#(
   parameter int WINDOW_LEN = 5,
   parameter int SUM_W      = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [SAMPLE_W-1:0] sample,
   output logic [SUM_W-1:0]    sum_in
);

   logic [SAMPLE_W-1:0] hist_ff [WINDOW_LEN];
   logic [SUM_W-1:0]    sum_ff;

   // oldest sample drops out as the new one enters
   assign sum_in = sum_ff + SUM_W'(sample) - SUM_W'(hist_ff[WINDOW_LEN-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (advance) begin
         sum_ff     <= sum_in;
         hist_ff[0] <= sample;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

endmodule

[rtl/core/dual_channel_beacon_direction_unit.sv]
`timescale 1ns / 1ps

// Beacon direction finder. Each transfer on req_chan carries one left and one
// right sensor sample; each goes into a sliding window of the last WINDOW_LEN
// samples (zero at reset) with a running sum. The updated sums are compared
// with detect and arrive thresholds scaled by WINDOW_LEN, so the averages are
// tested exactly without division. One result leaves on rsp_chan for every
// request, taken from the result register; a new request is taken every cycle,
// also while a result waits, as long as the result register is free or being
// drained in that cycle. Latency is set by the single result register.
// Thresholds are written on csr_chan (index 0 detect, 1 arrive) by the user
// only while idle (not enforced by the block); other indexes are ignored.

module dual_channel_beacon_direction_unit
   import bdu_pkg::*;
#(
   parameter int WINDOW_LEN = 5
) (
   input  logic      clock,
   input  logic      reset,
   bdu_req_if.sink   req_chan,
   bdu_rsp_if.source rsp_chan,
   bdu_csr_if.sink   csr_chan
);

   localparam int SUM_W = $clog2(SAMPLE_MAX * WINDOW_LEN + 1);
   localparam int EXT_W = SUM_W + OUT_SUM_W;
   localparam int DETECT_RESET_SCALED = DETECT_RESET * WINDOW_LEN;
   localparam int ARRIVE_RESET_SCALED = ARRIVE_RESET * WINDOW_LEN;

   logic [SUM_W-1:0]     detect_scaled_ff;
   logic [SUM_W-1:0]     arrive_scaled_ff;
   logic [SUM_W-1:0]     csr_scaled;

   logic                 accept;
   logic [SUM_W-1:0]     left_sum_in;
   logic [SUM_W-1:0]     right_sum_in;
   logic [EXT_W-1:0]     left_ext;
   logic [EXT_W-1:0]     right_ext;
   logic                 left_det;
   logic                 right_det;
   dir_type              dir_in;
   logic                 arrived_in;

   logic                 valid_ff;
   dir_type              dir_ff;
   logic                 arrived_ff;
   logic [OUT_SUM_W-1:0] left_out_ff;
   logic [OUT_SUM_W-1:0] right_out_ff;

   assign req_chan.ready = !valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign csr_scaled = SUM_W'(csr_chan.data) * SUM_W'(WINDOW_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_scaled_ff <= SUM_W'(DETECT_RESET_SCALED);
         arrive_scaled_ff <= SUM_W'(ARRIVE_RESET_SCALED);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_DETECT_THRESHOLD: detect_scaled_ff <= csr_scaled;
            CSR_ARRIVE_THRESHOLD: arrive_scaled_ff <= csr_scaled;
            default: ;
         endcase
      end
   end

   bdu_window #(.WINDOW_LEN(WINDOW_LEN), .SUM_W(SUM_W)) u_left (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .sample  (req_chan.left_sample),
      .sum_in  (left_sum_in)
   );

   bdu_window #(.WINDOW_LEN(WINDOW_LEN), .SUM_W(SUM_W)) u_right (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .sample  (req_chan.right_sample),
      .sum_in  (right_sum_in)
   );

   always_comb begin
      left_det  = left_sum_in > detect_scaled_ff;
      right_det = right_sum_in > detect_scaled_ff;
      if (left_det && right_det) begin
         // tie goes right
         dir_in = (left_sum_in > right_sum_in) ? DIR_LEFT : DIR_RIGHT;
      end else if (left_det) begin
         dir_in = DIR_LEFT;
      end else if (right_det) begin
         dir_in = DIR_RIGHT;
      end else begin
         dir_in = DIR_FRONT;
      end
      arrived_in = (left_sum_in > arrive_scaled_ff) || (right_sum_in > arrive_scaled_ff);
   end

   assign left_ext  = EXT_W'(left_sum_in);
   assign right_ext = EXT_W'(right_sum_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dir_ff       <= dir_in;
         arrived_ff   <= arrived_in;
         left_out_ff  <= left_ext[OUT_SUM_W-1:0];
         right_out_ff <= right_ext[OUT_SUM_W-1:0];
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.direction        = dir_ff;
   assign rsp_chan.arrived          = arrived_ff;
   assign rsp_chan.left_window_sum  = left_out_ff;
   assign rsp_chan.right_window_sum = right_out_ff;

endmodule

[rtl/core/bdu_checker.sv]
`timescale 1ns / 1ps

module bdu_checker
   import bdu_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_direction,
   input logic                 rsp_arrived,
   input logic [OUT_SUM_W-1:0] rsp_left_sum,
   input logic [OUT_SUM_W-1:0] rsp_right_sum
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_direction) &&
         $stable(rsp_arrived) && $stable(rsp_left_sum) && $stable(rsp_right_sum))
      else $error("stalled result changed");

   // every request transfer produces a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request transfer without result");

   // input stalls only behind a blocked result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result register free");

   // drained result with no new transfer leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result repeated");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_direction != 2'd3)
      else $error("invalid direction code");

endmodule

bind dual_channel_beacon_direction_unit bdu_checker u_bdu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_direction (rsp_chan.direction),
   .rsp_arrived   (rsp_chan.arrived),
   .rsp_left_sum  (rsp_chan.left_window_sum),
   .rsp_right_sum (rsp_chan.right_window_sum)
);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
   import bdu_pkg::*;

   localparam int WINDOW_LEN    = 5;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 11;
   localparam int PHASE_ITEMS   = 100;
   localparam int HOLD_CYCLES   = 150;
   localparam int HOLD_AFTER    = 300;
   localparam int IDLE_PCT      = 24;
   localparam int QUIET_PHASE   = 4;
   localparam int CSR_IDX_TOP   = 2**CSR_IDX_W - 1;
   localparam int DIRECTED_ROWS = 24;

   typedef logic [SAMPLE_W-1:0]  sample_t;
   typedef logic [OUT_SUM_W-1:0] wsum_t;
   typedef logic [CSR_IDX_W-1:0] csr_idx_t;

   typedef struct packed {
      dir_type direction;
      logic    arrived;
      wsum_t   left_sum;
      wsum_t   right_sum;
   } bearing_t;

   typedef struct {
      sample_t  left;
      sample_t  right;
      bit       typed;
      bearing_t want;
   } stim_row_t;

   localparam bearing_t NO_WANT = '{DIR_FRONT, 1'b0, 13'd0, 13'd0};

   logic clock = 1'b0;
   logic reset;

   bdu_req_if req_chan ();
   bdu_rsp_if rsp_chan ();
   bdu_csr_if csr_chan ();

   dual_channel_beacon_direction_unit #(
      .WINDOW_LEN (WINDOW_LEN)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Window state and thresholds as the block should hold them
   sample_t     left_hist [WINDOW_LEN];
   sample_t     right_hist [WINDOW_LEN];
   int unsigned left_acc;
   int unsigned right_acc;
   int unsigned slot;
   sample_t     detect_thr;
   sample_t     arrive_thr;

   bearing_t bearing_queue [$];
   int       mismatches;
   int       results_seen;
   int       items_sent;
   int       csr_writes;
   int       arrivals;
   int       dir_hits [3];
   bit       quiet;
   int       cycles_run;

   // Ramp up from reset to full scale, then drain back to silence; the rest probe
   // each side of the detect limit, both-seen ordering and bit patterns.
   stim_row_t directed_rows [DIRECTED_ROWS] = '{
      '{10'd0,    10'd0,    1'b1, '{DIR_FRONT, 1'b0, 13'd0,    13'd0}},
      '{10'd1023, 10'd0,    1'b1, '{DIR_LEFT,  1'b0, 13'd1023, 13'd0}},
      '{10'd0,    10'd1023, 1'b1, '{DIR_RIGHT, 1'b0, 13'd1023, 13'd1023}},
      '{10'd1023, 10'd1023, 1'b1, '{DIR_RIGHT, 1'b0, 13'd2046, 13'd2046}},
      '{10'd1023, 10'd1023, 1'b1, '{DIR_RIGHT, 1'b1, 13'd3069, 13'd3069}},
      '{10'd1023, 10'd1023, 1'b1, '{DIR_RIGHT, 1'b1, 13'd4092, 13'd4092}},
      '{10'd1023, 10'd1023, 1'b1, '{DIR_RIGHT, 1'b1, 13'd4092, 13'd5115}},
      '{10'd1023, 10'd1023, 1'b1, '{DIR_RIGHT, 1'b1, 13'd5115, 13'd5115}},
      '{10'd0,    10'd0,    1'b0, NO_WANT},
      '{10'd0,    10'd0,    1'b0, NO_WANT},
      '{10'd0,    10'd0,    1'b0, NO_WANT},
      '{10'd0,    10'd0,    1'b0, NO_WANT},
      '{10'd0,    10'd0,    1'b1, '{DIR_FRONT, 1'b0, 13'd0,    13'd0}},
      '{10'd51,   10'd0,    1'b0, NO_WANT},
      '{10'd0,    10'd50,   1'b0, NO_WANT},
      '{10'd0,    10'd1,    1'b0, NO_WANT},
      '{10'd300,  10'd0,    1'b0, NO_WANT},
      '{10'd0,    10'd400,  1'b0, NO_WANT},
      '{10'd1,    10'd2,    1'b0, NO_WANT},
      '{10'h200,  10'h2AA,  1'b0, NO_WANT},
      '{10'h155,  10'h2AA,  1'b0, NO_WANT},
      '{10'h2AA,  10'h155,  1'b0, NO_WANT},
      '{10'd1000, 10'd999,  1'b0, NO_WANT},
      '{10'd999,  10'd1000, 1'b0, NO_WANT}
   };

   function automatic bearing_t advance_windows(input sample_t ls, input sample_t rs);
      bearing_t    res;
      bit          l_seen;
      bit          r_seen;
      int unsigned detect_lim;
      int unsigned arrive_lim;
      left_acc         = left_acc - left_hist[slot] + ls;
      right_acc        = right_acc - right_hist[slot] + rs;
      left_hist[slot]  = ls;
      right_hist[slot] = rs;
      slot             = (slot == WINDOW_LEN - 1) ? 0 : slot + 1;
      detect_lim       = detect_thr * WINDOW_LEN;
      arrive_lim       = arrive_thr * WINDOW_LEN;
      l_seen           = left_acc > detect_lim;
      r_seen           = right_acc > detect_lim;
      // both seen: strictly larger left wins, a tie goes right
      if (l_seen && r_seen) begin
         res.direction = (left_acc > right_acc) ? DIR_LEFT : DIR_RIGHT;
      end else if (l_seen) begin
         res.direction = DIR_LEFT;
      end else if (r_seen) begin
         res.direction = DIR_RIGHT;
      end else begin
         res.direction = DIR_FRONT;
      end
      res.arrived   = (left_acc > arrive_lim) || (right_acc > arrive_lim);
      res.left_sum  = wsum_t'(left_acc);
      res.right_sum = wsum_t'(right_acc);
      return res;
   endfunction

   function automatic sample_t pick_sample();
      int centre;
      case ($urandom_range(9))
         0: return $urandom_range(1) ? sample_t'(SAMPLE_MAX) : '0;
         1, 2: centre = int'(detect_thr) + int'($urandom_range(40)) - 20;
         3: centre = int'(arrive_thr) + int'($urandom_range(40)) - 20;
         4: return '0;
         default: return sample_t'($urandom_range(SAMPLE_MAX));
      endcase
      if (centre < 0) centre = 0;
      if (centre > SAMPLE_MAX) centre = SAMPLE_MAX;
      return sample_t'(centre);
   endfunction

   task automatic send_pair(input sample_t ls, input sample_t rs, input bit typed,
                            input bearing_t want);
      bearing_t predicted;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.left_sample  <= ls;
      req_chan.right_sample <= rs;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = advance_windows(ls, rs);
      bearing_queue.push_back(typed ? want : predicted);
      items_sent++;
      dir_hits[int'(predicted.direction)]++;
      arrivals += predicted.arrived;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (bearing_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write both thresholds with a stray index in between; the stray one must be dropped
   task automatic apply_thresholds(input sample_t det, input sample_t arr);
      csr_idx_t idx [3];
      sample_t  val [3];
      idx[0] = CSR_DETECT_THRESHOLD;
      val[0] = det;
      idx[1] = csr_idx_t'($urandom_range(CSR_IDX_TOP, int'(CSR_ARRIVE_THRESHOLD) + 1));
      val[1] = sample_t'($urandom_range(SAMPLE_MAX));
      idx[2] = CSR_ARRIVE_THRESHOLD;
      val[2] = arr;
      for (int k = 0; k < 3; k++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx[k];
         csr_chan.data  <= val[k];
         do @(posedge clock); while (csr_chan.ready !== 1'b1);
         if (idx[k] == CSR_DETECT_THRESHOLD) begin
            detect_thr = val[k];
         end else if (idx[k] == CSR_ARRIVE_THRESHOLD) begin
            arrive_thr = val[k];
         end
         csr_writes++;
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      sample_t det_next;
      sample_t arr_next;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.left_sample  = '0;
      req_chan.right_sample = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = CSR_DETECT_THRESHOLD;
      csr_chan.data         = '0;
      foreach (left_hist[k]) begin
         left_hist[k]  = '0;
         right_hist[k] = '0;
      end
      left_acc   = 0;
      right_acc  = 0;
      slot       = 0;
      detect_thr = sample_t'(DETECT_RESET);
      arrive_thr = sample_t'(ARRIVE_RESET);
      quiet      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i].left, directed_rows[i].right, directed_rows[i].typed,
                   directed_rows[i].want);
      end
      settle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               det_next = '0;
               arr_next = '0;
            end
            1: begin
               det_next = sample_t'(SAMPLE_MAX);
               arr_next = sample_t'(SAMPLE_MAX);
            end
            2: begin
               det_next = '0;
               arr_next = sample_t'(SAMPLE_MAX);
            end
            3: begin
               det_next = sample_t'(SAMPLE_MAX);
               arr_next = '0;
            end
            QUIET_PHASE: begin
               det_next = sample_t'(DETECT_RESET);
               arr_next = sample_t'(ARRIVE_RESET);
            end
            default: begin
               det_next = sample_t'($urandom_range(400));
               arr_next = sample_t'($urandom_range(SAMPLE_MAX, 200));
            end
         endcase
         apply_thresholds(det_next, arr_next);
         quiet = (p == QUIET_PHASE);
         repeat (PHASE_ITEMS) send_pair(pick_sample(), pick_sample(), 1'b0, NO_WANT);
         settle();
      end
      quiet = 1'b0;
      repeat (8) @(posedge clock);

      $display("Streamed %0d sample pairs under %0d threshold settings (%0d register writes),",
               items_sent, PHASES + 1, csr_writes);
      $display("checked %0d results: front/left/right %0d/%0d/%0d, arrival %0d, mismatches %0d",
               results_seen, dir_hits[0], dir_hits[1], dir_hits[2], arrivals, mismatches);
      if (mismatches == 0 && bearing_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Result side: random back-pressure, one long hold to fill the block, none when quiet
   initial begin
      int hold_left;
      bit hold_done;
      hold_left      = 0;
      hold_done      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      bearing_t want;
      bearing_t got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_seen++;
         got = {rsp_chan.direction, rsp_chan.arrived, rsp_chan.left_window_sum,
                rsp_chan.right_window_sum};
         if (bearing_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] unexpected transfer: dir %0d arr %0d sums %0d/%0d", $realtime,
                        got.direction, got.arrived, got.left_sum, got.right_sum);
            end
         end else begin
            want = bearing_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] mismatch: dir %0d/%0d arr %0d/%0d left %0d/%0d right %0d/%0d",
                           $realtime, want.direction, got.direction, want.arrived, got.arrived,
                           want.left_sum, got.left_sum, want.right_sum, got.right_sum);
               end
            end
         end
      end
   end

   initial begin
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding", cycles_run,
               bearing_queue.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

[dual_channel_beacon_direction_unit.f]
rtl/core/bdu_pkg.sv
rtl/core/bdu_if.sv
rtl/core/bdu_window.sv
rtl/core/dual_channel_beacon_direction_unit.sv
rtl/core/bdu_checker.sv
verif/tb.sv
